@@ hw/rtl/dimc_pkg.sv @@
package dimc_pkg;

	localparam int MAX_ROW   = 1024;
	localparam int ROW_AW    = $clog2(MAX_ROW);
	localparam int LEN_W     = ROW_AW + 1;

	// command queue between front and back
	localparam int CQ_DEPTH  = 4;
	localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W  = CQ_PTR_W + 1;

	// result queue at the output
	localparam int OQ_DEPTH  = 8;
	localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W  = OQ_PTR_W + 1;

	localparam int CFG_DW    = 11;
	localparam int CFG_IW    = 3;

	localparam logic [CFG_IW-1:0] REG_ROW_LENGTH = 3'd0;
	localparam logic [CFG_IW-1:0] REG_PADDING    = 3'd1;
	localparam logic [CFG_IW-1:0] REG_STRIDE     = 3'd2;
	localparam logic [CFG_IW-1:0] REG_DILATION   = 3'd3;
	localparam logic [CFG_IW-1:0] REG_DEFORMABLE = 3'd4;
	localparam logic [CFG_IW-1:0] REG_MODULATED  = 3'd5;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	typedef struct packed {
		logic [10:0] row_length;
		logic [9:0]  padding;
		logic [6:0]  stride;
		logic [6:0]  dilation;
		logic        deformable;
	} front_cfg_t;

	// one classified item: a load, or a compute with its two neighbor reads
	typedef struct packed {
		logic              is_load;
		logic [ROW_AW-1:0] waddr;
		logic [15:0]       wdata;
		logic [ROW_AW-1:0] lo_addr;
		logic [ROW_AW-1:0] hi_addr;
		logic              lo_ok;
		logic              hi_ok;
		logic [7:0]        frac;
		logic [15:0]       mask;
	} cmd_entry_t;

endpackage

@@ hw/rtl/dimc_front.sv @@
module dimc_front import dimc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                cmd,
	input  logic [9:0]          sample_addr,
	input  logic signed [15:0]  sample_value,
	input  logic [9:0]          out_pos,
	input  logic [3:0]          tap,
	input  logic signed [23:0]  offset_value,
	input  logic signed [15:0]  mask_value,
	input  front_cfg_t          cfg,
	input  logic [CQ_CNT_W-1:0] q_count,
	output logic                ent_valid,
	output cmd_entry_t          ent
);

	logic [16:0]        base;
	logic [10:0]        tap_off;
	logic signed [18:0] x_pos;
	logic signed [27:0] pos_full;
	logic [CQ_CNT_W:0]  pending;

	logic               v_s1;
	logic               load_s1;
	logic [ROW_AW-1:0]  addr_s1;
	logic [15:0]        sval_s1;
	logic [15:0]        mask_s1;
	logic signed [27:0] pos_s1;

	logic               v_s2;
	cmd_entry_t         ent_s2;

	logic [LEN_W-1:0]   len;
	logic               zero;
	logic [10:0]        xl;
	logic [10:0]        xl_inc;

	// items already in flight count against queue room
	assign pending = {1'b0, q_count} + {{CQ_CNT_W{1'b0}}, v_s1} + {{CQ_CNT_W{1'b0}}, v_s2};
	assign full = pending >= (CQ_CNT_W + 1)'(CQ_DEPTH);

	assign base    = 17'(out_pos) * 17'(cfg.stride);
	assign tap_off = 11'(tap) * 11'(cfg.dilation);
	assign x_pos   = $signed({2'b00, base}) + $signed({8'h00, tap_off})
		- $signed({9'h000, cfg.padding});
	assign pos_full = $signed({x_pos[18], x_pos, 8'h00})
		+ (cfg.deformable ? $signed({{4{offset_value[23]}}, offset_value}) : 28'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= push && !full;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		load_s1 <= (cmd == CMD_LOAD);
		addr_s1 <= sample_addr;
		sval_s1 <= sample_value;
		mask_s1 <= mask_value;
		pos_s1  <= pos_full;
	end

	// classify: position P is in Q.8; it samples nothing outside (-256, len*256)
	assign len    = (cfg.row_length > LEN_W'(MAX_ROW)) ? LEN_W'(MAX_ROW) : cfg.row_length;
	assign zero   = (pos_s1 <= -28'sd256) || (pos_s1 >= $signed({9'h000, len, 8'h00}));
	assign xl     = pos_s1[18:8];
	assign xl_inc = xl + 11'd1;

	always_ff @(posedge clk) begin
		ent_s2.is_load <= load_s1;
		ent_s2.waddr   <= addr_s1;
		ent_s2.wdata   <= sval_s1;
		ent_s2.lo_addr <= xl[ROW_AW-1:0];
		ent_s2.hi_addr <= xl_inc[ROW_AW-1:0];
		ent_s2.lo_ok   <= !zero && !pos_s1[27];
		ent_s2.hi_ok   <= !zero && (xl_inc < len);
		ent_s2.frac    <= pos_s1[7:0];
		ent_s2.mask    <= mask_s1;
	end

	assign ent_valid = v_s2;
	assign ent       = ent_s2;

endmodule

@@ hw/rtl/dimc_cmdq.sv @@
module dimc_cmdq import dimc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cmd_entry_t          push_data,
	input  logic                pop,
	output logic                empty,
	output logic [CQ_CNT_W-1:0] count,
	output cmd_entry_t          head
);

	cmd_entry_t          slot_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_q;
	logic [CQ_PTR_W-1:0] rd_q;
	logic [CQ_CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + CQ_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + CQ_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CQ_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	assign empty = (count_q == '0);
	assign count = count_q;
	assign head  = slot_q[rd_q];

endmodule

@@ hw/rtl/dimc_back.sv @@
module dimc_back import dimc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  cmd_entry_t         q_head,
	output logic               q_pop,
	input  logic               modulated,
	input  logic               pop,
	output logic               empty,
	output logic signed [31:0] column_value
);

	logic [15:0]         row_mem_q [MAX_ROW];

	logic                v_s1;
	logic [15:0]         rd0_s1;
	logic [15:0]         rd1_s1;
	logic                lo_ok_s1;
	logic                hi_ok_s1;
	logic [7:0]          frac_s1;
	logic [15:0]         mask_s1;

	logic                v_s2;
	logic signed [25:0]  val_s2;
	logic [15:0]         mask_s2;

	logic                v_s3;
	logic signed [25:0]  val_s3;
	logic signed [41:0]  prod_s3;

	logic signed [15:0]  smp0;
	logic signed [15:0]  smp1;
	logic signed [16:0]  diff;
	logic signed [8:0]   frac_sg;
	logic signed [25:0]  interp;
	logic signed [41:0]  rounded;
	logic signed [31:0]  result;

	logic [31:0]         oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_q;
	logic [OQ_PTR_W-1:0] oq_rd_q;
	logic [OQ_CNT_W-1:0] oq_count_q;
	logic [OQ_CNT_W:0]   reserved;
	logic                oq_pop;

	// results in flight hold a slot in the result queue
	assign reserved = {1'b0, oq_count_q} + {{OQ_CNT_W{1'b0}}, v_s1}
		+ {{OQ_CNT_W{1'b0}}, v_s2} + {{OQ_CNT_W{1'b0}}, v_s3};
	assign q_pop = !q_empty && (reserved < (OQ_CNT_W + 1)'(OQ_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= q_pop && !q_head.is_load;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// row store: loads and reads stay in queue order
	always_ff @(posedge clk) begin
		if (q_pop && q_head.is_load) begin
			row_mem_q[q_head.waddr] <= q_head.wdata;
		end
		rd0_s1 <= row_mem_q[q_head.lo_addr];
		rd1_s1 <= row_mem_q[q_head.hi_addr];
	end

	always_ff @(posedge clk) begin
		lo_ok_s1 <= q_head.lo_ok;
		hi_ok_s1 <= q_head.hi_ok;
		frac_s1  <= q_head.frac;
		mask_s1  <= q_head.mask;
	end

	// (256-f)*s0 + f*s1 == s0*256 + f*(s1-s0)
	assign smp0    = lo_ok_s1 ? $signed(rd0_s1) : 16'sd0;
	assign smp1    = hi_ok_s1 ? $signed(rd1_s1) : 16'sd0;
	assign diff    = $signed({smp1[15], smp1}) - $signed({smp0[15], smp0});
	assign frac_sg = $signed({1'b0, frac_s1});
	assign interp  = $signed({{2{smp0[15]}}, smp0, 8'h00}) + 26'(frac_sg) * 26'(diff);

	always_ff @(posedge clk) begin
		val_s2  <= interp;
		mask_s2 <= mask_s1;
		val_s3  <= val_s2;
		prod_s3 <= 42'(val_s2) * 42'($signed(mask_s2));
	end

	// Q2.14 mask: round half up, then drop 14 bits; never leaves 32-bit range
	assign rounded = prod_s3 + 42'sd8192;
	assign result  = modulated ? $signed({{4{rounded[41]}}, rounded[41:14]})
		: $signed({{6{val_s3[25]}}, val_s3});

	assign oq_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q    <= '0;
			oq_rd_q    <= '0;
			oq_count_q <= '0;
		end else begin
			if (v_s3) begin
				oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
			end
			if (v_s3 && !oq_pop) begin
				oq_count_q <= oq_count_q + OQ_CNT_W'(1);
			end else if (oq_pop && !v_s3) begin
				oq_count_q <= oq_count_q - OQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			oq_q[oq_wr_q] <= result;
		end
	end

	assign empty        = (oq_count_q == '0);
	assign column_value = $signed(oq_q[oq_rd_q]);

endmodule

@@ hw/rtl/deformable_im2col_1d_sampler.sv @@
// One-row deformable im2col sampler. Load transactions (cmd 0) write one
// 16-bit sample into a 1024-entry row store and give no result; compute
// transactions (cmd 1) give one column_value each, in order. One transaction
// is taken per clock while full is low: the front end forms and classifies
// the sampling position in two stages, a 4-entry command queue decouples it
// from the back end, which reads both neighbors from the dual-read row store,
// interpolates, applies the mask and lands the result in an 8-entry output
// queue. full rises only when the queues and stages in flight are taken up.
// The row store has no reset; a sample must be loaded before it is read.
// Configuration writes are taken at any cycle but must be made only while the
// block is idle.
module deformable_im2col_1d_sampler import dimc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_IW-1:0]  cfg_index,
	input  logic [CFG_DW-1:0]  cfg_data,
	input  logic               push,
	output logic               full,
	input  logic               cmd,
	input  logic [9:0]         sample_addr,
	input  logic signed [15:0] sample_value,
	input  logic [9:0]         out_pos,
	input  logic [3:0]         tap,
	input  logic signed [23:0] offset_value,
	input  logic signed [15:0] mask_value,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] column_value
);

	logic [10:0]         row_length_q;
	logic [9:0]          padding_q;
	logic [6:0]          stride_q;
	logic [6:0]          dilation_q;
	logic                deformable_q;
	logic                modulated_q;

	front_cfg_t          fcfg;
	logic                ent_valid;
	cmd_entry_t          ent;
	logic                cq_pop;
	logic                cq_empty;
	logic [CQ_CNT_W-1:0] cq_count;
	cmd_entry_t          cq_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= 11'd1024;
			padding_q    <= '0;
			stride_q     <= 7'd1;
			dilation_q   <= 7'd1;
			deformable_q <= 1'b1;
			modulated_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_LENGTH: row_length_q <= cfg_data[10:0];
				REG_PADDING:    padding_q    <= cfg_data[9:0];
				REG_STRIDE:     stride_q     <= cfg_data[6:0];
				REG_DILATION:   dilation_q   <= cfg_data[6:0];
				REG_DEFORMABLE: deformable_q <= cfg_data[0];
				REG_MODULATED:  modulated_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign fcfg.row_length = row_length_q;
	assign fcfg.padding    = padding_q;
	assign fcfg.stride     = stride_q;
	assign fcfg.dilation   = dilation_q;
	assign fcfg.deformable = deformable_q;

	dimc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.sample_addr  (sample_addr),
		.sample_value (sample_value),
		.out_pos      (out_pos),
		.tap          (tap),
		.offset_value (offset_value),
		.mask_value   (mask_value),
		.cfg          (fcfg),
		.q_count      (cq_count),
		.ent_valid    (ent_valid),
		.ent          (ent)
	);

	dimc_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ent_valid),
		.push_data (ent),
		.pop       (cq_pop),
		.empty     (cq_empty),
		.count     (cq_count),
		.head      (cq_head)
	);

	dimc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (cq_empty),
		.q_head       (cq_head),
		.q_pop        (cq_pop),
		.modulated    (modulated_q),
		.pop          (pop),
		.empty        (empty),
		.column_value (column_value)
	);

endmodule
